// File: design/q2e_pkg.sv
// shared types, constants and functions for the quaternion to euler angle converter
package q2e_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TERM_W = 34;              // signed Q.28 term plus headroom
    localparam int CW = 40;                  // cordic x/y datapath width
    localparam int ZW = 20;                  // cordic angle width, Q.16
    localparam int SQ_W = 29;                // sqrt result width
    localparam int SQ_STEPS = 29;            // one result bit per stage
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [ZW-1:0] PI_Q13 = 20'sd25736;
    localparam logic signed [ZW-1:0] HALF_PI_Q13 = 20'sd12868;
    localparam logic signed [TERM_W-1:0] ONE_Q28 = 34'sd268435456;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 both_zero;
    } t_cvec;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] r;
        begin
            case (i)
                0: r = 20'sd51472;
                1: r = 20'sd30386;
                2: r = 20'sd16055;
                3: r = 20'sd8150;
                4: r = 20'sd4091;
                5: r = 20'sd2047;
                6: r = 20'sd1024;
                7: r = 20'sd512;
                8: r = 20'sd256;
                9: r = 20'sd128;
                10: r = 20'sd64;
                11: r = 20'sd32;
                12: r = 20'sd16;
                13: r = 20'sd8;
                14: r = 20'sd4;
                15: r = 20'sd2;
                16: r = 20'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // round-to-nearest of q.16 to q3.13 with saturation
    function automatic logic signed [ZW-1:0] to_q13(input logic signed [ZW-1:0] a,
                                                   input logic signed [ZW-1:0] lim);
        logic signed [ZW:0] s;
        logic signed [ZW-1:0] r;
        begin
            s = (ZW+1)'(a) + (ZW+1)'(4);
            r = ZW'(s >>> 3);
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return r;
        end
    endfunction

endpackage

// File: design/quaternion_to_euler_angles_top.sv
// quaternion to zyx euler angle converter, top level
//  channel  dir  signals                       word
//  s_axis   in   s_axis_tvalid/tready/tdata    x,y,z,w q1.14 (64 bits)
//  m_axis   out  m_axis_tvalid/tready/tdata    roll,yaw q3.13, pitch q2.13 (48 bits)
// one word accepted per cycle while m_axis is not stalled; stages in order:
// products, terms, square root, cordic, output register
// the 29 stage square root chain lies ahead of the 16 stage pitch cordic
// reset clears only the valid bits of the pipeline and output register
// a stall on m_axis freezes the whole pipeline while the output word waits
module quaternion_to_euler_angles_top
    import q2e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // roll_angle, pitch_angle, yaw_angle, pad
);

    localparam int LAT = 2 + SQ_STEPS + 1 + CORDIC_STEPS + 1;

    logic en;
    logic [LAT-1:0] r_vld;
    logic r_ovld;
    logic [47:0] r_odata;

    assign en = !r_ovld || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    // stage 0: products
    logic signed [15:0] qx, qy, qz, qw;
    assign qx = s_axis_tdata[15:0];
    assign qy = s_axis_tdata[31:16];
    assign qz = s_axis_tdata[47:32];
    assign qw = s_axis_tdata[63:48];

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_wx <= qw * qx; r_yz <= qy * qz; r_xx <= qx * qx;
            r_yy <= qy * qy; r_wy <= qw * qy; r_zx <= qz * qx;
            r_wz <= qw * qz; r_xy <= qx * qy; r_zz <= qz * qz;
        end
    end

    // stage 1: terms, pitch term clamped
    logic signed [TERM_W+1:0] n_t0, n_t1, n_t2, n_t3, n_t4;
    logic signed [TERM_W-1:0] r_t0, r_t1, r_t2, r_t3, r_t4;
    always_comb begin
        n_t0 = ((TERM_W+2)'(r_wx) + (TERM_W+2)'(r_yz)) <<< 1;
        n_t1 = (TERM_W+2)'(ONE_Q28) - (((TERM_W+2)'(r_xx) + (TERM_W+2)'(r_yy)) <<< 1);
        n_t2 = ((TERM_W+2)'(r_wy) - (TERM_W+2)'(r_zx)) <<< 1;
        n_t3 = ((TERM_W+2)'(r_wz) + (TERM_W+2)'(r_xy)) <<< 1;
        n_t4 = (TERM_W+2)'(ONE_Q28) - (((TERM_W+2)'(r_yy) + (TERM_W+2)'(r_zz)) <<< 1);
        if (n_t2 > (TERM_W+2)'(ONE_Q28)) n_t2 = (TERM_W+2)'(ONE_Q28);
        if (n_t2 < -(TERM_W+2)'(ONE_Q28)) n_t2 = -(TERM_W+2)'(ONE_Q28);
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t0 <= TERM_W'(n_t0); r_t1 <= TERM_W'(n_t1); r_t2 <= TERM_W'(n_t2);
            r_t3 <= TERM_W'(n_t3); r_t4 <= TERM_W'(n_t4);
        end
    end

    // square root operand, one multiplier
    logic [29:0] t2_abs;
    logic [56:0] sq_n;
    assign t2_abs = r_t2[TERM_W-1] ? 30'(-r_t2) : 30'(r_t2);
    assign sq_n = (57'd1 << 56) - 57'(t2_abs) * 57'(t2_abs);

    logic [SQ_W-1:0] root;
    q2e_isqrt u_sqrt (.i_clk(i_clk), .i_en(en), .i_n(sq_n), .o_root(root));

    // delay lines aligning the inputs of the three cordics
    localparam int DL = SQ_STEPS + 1;
    logic signed [TERM_W-1:0] r_d0 [0:DL-1];
    logic signed [TERM_W-1:0] r_d1 [0:DL-1];
    logic signed [TERM_W-1:0] r_d2 [0:DL-1];
    logic signed [TERM_W-1:0] r_d3 [0:DL-1];
    logic signed [TERM_W-1:0] r_d4 [0:DL-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0[0] <= r_t0; r_d1[0] <= r_t1; r_d2[0] <= r_t2;
            r_d3[0] <= r_t3; r_d4[0] <= r_t4;
            for (int k = 1; k < DL; k++) begin
                r_d0[k] <= r_d0[k-1]; r_d1[k] <= r_d1[k-1]; r_d2[k] <= r_d2[k-1];
                r_d3[k] <= r_d3[k-1]; r_d4[k] <= r_d4[k-1];
            end
        end
    end

    logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;
    q2e_cordic u_roll (.i_clk(i_clk), .i_en(en), .i_y(CW'(r_d0[DL-1])),
                       .i_x(CW'(r_d1[DL-1])), .o_z(z_roll));
    q2e_cordic u_pitch (.i_clk(i_clk), .i_en(en), .i_y(CW'(r_d2[DL-1])),
                        .i_x(CW'({1'b0, root})), .o_z(z_pitch));
    q2e_cordic u_yaw (.i_clk(i_clk), .i_en(en), .i_y(CW'(r_d3[DL-1])),
                      .i_x(CW'(r_d4[DL-1])), .o_z(z_yaw));

    // final rounding and output register
    logic signed [ZW-1:0] a_roll, a_pitch, a_yaw;
    assign a_roll  = to_q13(z_roll, PI_Q13);
    assign a_pitch = to_q13(z_pitch, HALF_PI_Q13);
    assign a_yaw   = to_q13(z_yaw, PI_Q13);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_vld[LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) r_odata <= {1'b0, a_yaw[15:0], a_pitch[14:0], a_roll[15:0]};
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready && !en |=> $stable(m_axis_tdata))
        else $error("output changed during stall");
    a_vld_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped during stall");
    a_pitch_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd12868 &&
                           $signed(m_axis_tdata[30:16]) >= -15'sd12868))
        else $error("pitch out of range");
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47] == 1'b0)
        else $error("pad bit set");

endmodule

// File: design/q2e_cordic.sv
// pipelined vectoring cordic atan2, one iteration per stage
module q2e_cordic
    import q2e_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [CW-1:0]     i_y,
    input  logic signed [CW-1:0]     i_x,
    output logic signed [ZW-1:0]     o_z
);

    t_cvec r_st [0:CORDIC_STEPS];
    t_cvec n_pre;

    // pre-rotation into the right half plane
    always_comb begin
        n_pre.x = i_x;
        n_pre.y = i_y;
        n_pre.z = '0;
        n_pre.both_zero = (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            if (i_y >= 0) begin
                n_pre.z = HALF_PI_Q16;
                n_pre.x = i_y;
                n_pre.y = -i_x;
            end else begin
                n_pre.z = -HALF_PI_Q16;
                n_pre.x = -i_y;
                n_pre.y = i_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_st[0] <= n_pre;
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_it
        t_cvec n_st;
        always_comb begin
            n_st.both_zero = r_st[g].both_zero;
            if (r_st[g].y < 0) begin
                n_st.x = r_st[g].x - (r_st[g].y >>> g);
                n_st.y = r_st[g].y + (r_st[g].x >>> g);
                n_st.z = r_st[g].z - atan_entry(g);
            end else begin
                n_st.x = r_st[g].x + (r_st[g].y >>> g);
                n_st.y = r_st[g].y - (r_st[g].x >>> g);
                n_st.z = r_st[g].z + atan_entry(g);
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_st[g+1] <= n_st;
        end
    end

    // zero vector gives angle zero
    assign o_z = r_st[CORDIC_STEPS].both_zero ? '0 : r_st[CORDIC_STEPS].z;

endmodule

// File: design/q2e_isqrt.sv
// pipelined bitwise trial square root of i_n (2^56 - t^2 at the top level), one result bit per stage
module q2e_isqrt
    import q2e_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [56:0]              i_n,
    output logic [SQ_W-1:0]          o_root
);

    logic [57:0]     r_rem  [0:SQ_STEPS];
    logic [SQ_W-1:0] r_root [0:SQ_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= {1'b0, i_n};
            r_root[0] <= '0;
        end
    end

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_bit
        localparam int B = SQ_STEPS - 1 - g;
        logic [57:0]     n_trial;
        logic [SQ_W-1:0] n_cand;
        always_comb begin
            n_cand  = r_root[g] | (SQ_W'(1) << B);
            n_trial = 58'(n_cand) * 58'(n_cand);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= r_rem[g];
                r_root[g+1] <= (n_trial <= r_rem[g]) ? n_cand : r_root[g];
            end
        end
    end

    assign o_root = r_root[SQ_STEPS];

endmodule

// File: bench/tb.sv
// self-checking bench for the quaternion to euler angle converter
`timescale 1ns / 100ps

module tb;
    import q2e_pkg::*;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } t_angles;

    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic [15:0] w;
        logic        chk;
        t_angles     ang;
    } t_row;

    localparam longint ONE28 = 64'sd268435456;
    localparam longint HALF_PI16 = 64'sd102944;
    localparam longint PI13 = 64'sd25736;
    localparam longint HALF_PI13 = 64'sd12868;
    localparam int PH_NONE = 0;
    localparam int PH_SRC = 1;
    localparam int PH_SNK = 2;
    localparam int PH_BOTH = 3;
    localparam int RANDOM_WORDS = 700;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // quat_x, quat_y, quat_z, quat_w
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // roll_angle, pitch_angle, yaw_angle, pad

    t_angles angle_queue[$];
    int      errors = 0;
    int      cycles = 0;
    int      phase = PH_NONE;

    quaternion_to_euler_angles_top dut (.*);

    always #6 i_clk = ~i_clk;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint vec_angle(longint y, longint x);
        longint a;
        longint t;
        longint dx;
        longint dy;
        longint tab[17];
        tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                256, 128, 64, 32, 16, 8, 4, 2, 1};
        a = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                a = HALF_PI16; x = y; y = -t;
            end else begin
                a = -HALF_PI16; x = -y; y = t;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y < 0) begin
                x -= dx; y += dy; a -= (i < 17) ? tab[i] : 0;
            end else begin
                x += dx; y -= dy; a += (i < 17) ? tab[i] : 0;
            end
        end
        return a;
    endfunction

    function automatic longint round_sat(longint a, longint lim);
        longint r;
        r = (a + 4) >>> 3;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles euler_of(logic [15:0] qx, logic [15:0] qy,
                                         logic [15:0] qz, logic [15:0] qw);
        longint x, y, z, w, t0, t1, t2, t3, t4, c;
        t_angles r;
        x = longint'($signed(qx));
        y = longint'($signed(qy));
        z = longint'($signed(qz));
        w = longint'($signed(qw));
        t0 = 2 * (w * x + y * z);
        t1 = ONE28 - 2 * (x * x + y * y);
        t2 = 2 * (w * y - z * x);
        t3 = 2 * (w * z + x * y);
        t4 = ONE28 - 2 * (y * y + z * z);
        if (t2 > ONE28) t2 = ONE28;
        if (t2 < -ONE28) t2 = -ONE28;
        c = root_floor(ONE28 * ONE28 - t2 * t2);
        r.roll = 16'(round_sat(vec_angle(t0, t1), PI13));
        r.pitch = 15'(round_sat(vec_angle(t2, c), HALF_PI13));
        r.yaw = 16'(round_sat(vec_angle(t3, t4), PI13));
        return r;
    endfunction

    function automatic t_row row(int x, int y, int z, int w, bit chk = 0,
                                 int rl = 0, int pt = 0, int yw = 0);
        t_row r;
        r.x = 16'(x); r.y = 16'(y); r.z = 16'(z); r.w = 16'(w);
        r.chk = chk;
        r.ang.roll = 16'(rl); r.ang.pitch = 15'(pt); r.ang.yaw = 16'(yw);
        return r;
    endfunction

    task automatic send_word(t_row r);
        t_angles e;
        if (phase == PH_SRC || phase == PH_BOTH) begin
            while ($urandom_range(99) < ((phase == PH_SRC) ? 83 : 38)) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        e = euler_of(r.x, r.y, r.z, r.w);
        if (r.chk && e !== r.ang)
            $error("table row for x=%0d disagrees with predictor", $signed(r.x));
        s_axis_tdata <= {r.w, r.z, r.y, r.x};
        s_axis_tvalid <= 1'b1;
        angle_queue.insert(angle_queue.size(), r.chk ? r.ang : e);
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [15:0] rand_q();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(32768)) - 16384);
            default: return 16'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic send_unit();
        real a, b, c, d, n;
        a = $signed($urandom_range(2000)) - 1000.0;
        b = $signed($urandom_range(2000)) - 1000.0;
        c = $signed($urandom_range(2000)) - 1000.0;
        d = $signed($urandom_range(2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        send_word(row($rtoi(a * 16384.0 / n), $rtoi(b * 16384.0 / n),
                      $rtoi(c * 16384.0 / n), $rtoi(d * 16384.0 / n)));
    endtask

    always @(posedge i_clk) begin
        if (phase == PH_SNK) m_axis_tready <= ($urandom_range(99) >= 83);
        else if (phase == PH_BOTH) m_axis_tready <= ($urandom_range(99) >= 38);
        else m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_angles got;
        t_angles exp_a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[46:0];
            if (angle_queue.size() == 0) begin
                $error("unexpected word %h", m_axis_tdata);
                errors++;
            end else begin
                exp_a = angle_queue.pop_front();
                if (got.roll !== exp_a.roll) begin
                    $error("roll_angle expected %0d got %0d", exp_a.roll, got.roll);
                    errors++;
                end
                if (got.pitch !== exp_a.pitch) begin
                    $error("pitch_angle expected %0d got %0d", exp_a.pitch, got.pitch);
                    errors++;
                end
                if (got.yaw !== exp_a.yaw) begin
                    $error("yaw_angle expected %0d got %0d", exp_a.yaw, got.yaw);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("quaternion_to_euler_angles_top test failed");
            $finish;
        end
    end

    initial begin
        t_row dir_rows[$];
        dir_rows = '{
            row(0, 0, 0, 16384, 1, 0, 0, 0),
            row(0, 0, 0, 0, 1, 0, 0, 0),
            row(16384, 0, 0, 0, 1, PI13, 0, 0),
            row(0, 16384, 0, 0, 1, PI13, 0, PI13),
            row(0, 0, 16384, 0, 1, 0, 0, PI13),
            row(0, 0, 0, -16384),
            row(-16384, 0, 0, 0),
            row(11585, 0, 0, 11585),
            row(0, 11585, 0, 11585),
            row(0, -11585, 0, 11585),
            row(0, 0, 11585, 11585),
            row(0, 0, -11585, 11585),
            row(16384, 16384, 16384, 16384),
            row(-16384, -16384, -16384, -16384),
            row(32767, 32767, 32767, 32767),
            row(-32768, -32768, -32768, -32768),
            row(-32768, 32767, -32768, 32767),
            row(16384, -16384, 16384, -16384),
            row(1, 0, 0, 0),
            row(-1, 1, -1, 1),
            row(8192, 8192, 8192, 8192),
            row(8192, 8192, 0, 0),
            row(0, 8192, 8192, 0),
            row(0, 16384, 0, 16384),
            row(0, -16384, 0, 16384)
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) send_word(dir_rows[k]);
        for (int p = PH_NONE; p <= PH_BOTH; p++) begin
            phase = p;
            for (int k = 0; k < RANDOM_WORDS / 4; k++) begin
                if ($urandom_range(3) == 0)
                    send_word(row(rand_q(), rand_q(), rand_q(), rand_q()));
                else
                    send_unit();
            end
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            repeat ($urandom_range(20)) @(posedge i_clk);
        end
        phase = PH_NONE;
        while (angle_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && angle_queue.size() == 0)
            $display("quaternion_to_euler_angles_top test passed");
        else
            $display("quaternion_to_euler_angles_top test failed");
        $finish;
    end

endmodule

// File: sim.f
design/q2e_pkg.sv
design/q2e_cordic.sv
design/q2e_isqrt.sv
design/quaternion_to_euler_angles_top.sv
bench/tb.sv
